// ===== hdl/tsg_pkg.sv =====
// Shared types, constants and the sine table for the tone generator.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package tsg_pkg;

    localparam int PHASE_BITS  = 32;
    localparam int LUT_DEPTH   = 1024;
    localparam int LUT_AW      = $clog2(LUT_DEPTH);

    localparam int MODE_W      = 3;
    localparam int FREQ_W      = 15;
    localparam int DUR_W       = 16;
    localparam int VOL_W       = 7;
    localparam int SAMPLE_W    = 15;

    localparam longint unsigned RATE_HZ   = 44100;
    localparam longint unsigned FREQ_MIN  = 20;
    localparam longint unsigned FREQ_MAX  = 20000;
    localparam longint unsigned FREQ_INIT = 440;
    localparam longint unsigned VOL_MAX   = 100;
    localparam longint unsigned PEAK      = 16000;

    // gain = PEAK * volume / 100, kept as one register
    localparam longint unsigned GAIN_PER_PCT = PEAK / VOL_MAX;
    localparam int GAIN_W = $clog2(PEAK + 1);
    localparam longint unsigned GAIN_INIT = PEAK;

    // Q30 sine arithmetic
    localparam int Q_SHIFT = 30;
    localparam longint unsigned Q_ONE   = 64'd1 << Q_SHIFT;
    localparam longint unsigned HALF_PI = 64'd1686629713;
    localparam int SINE_W = 31;

    // increment = floor(f * 2^PHASE_BITS / RATE_HZ)
    //           = f * INC_WHOLE + floor(f * INC_REM / RATE_HZ)
    // the second term is a reciprocal multiply, exact for 15-bit f
    localparam longint unsigned PHASE_ONE = 64'd1 << PHASE_BITS;
    localparam longint unsigned INC_WHOLE = PHASE_ONE / RATE_HZ;
    localparam longint unsigned INC_REM   = PHASE_ONE - INC_WHOLE * RATE_HZ;
    localparam int FRAC_SHIFT = 31;
    localparam longint unsigned FRAC_M =
        ((INC_REM << FRAC_SHIFT) + RATE_HZ - 1) / RATE_HZ;
    localparam int INC_WHOLE_W = $clog2(INC_WHOLE + 1);
    localparam int FRAC_M_W    = $clog2(FRAC_M + 1);
    localparam longint unsigned INC_INIT = (FREQ_INIT << PHASE_BITS) / RATE_HZ;

    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE     = 3'd0,
        MODE_MS_TICK    = 3'd1,
        MODE_START_TIME = 3'd2,
        MODE_START_CONT = 3'd3,
        MODE_STOP       = 3'd4,
        MODE_SET_FREQ   = 3'd5
    } mode_t;

    typedef logic [SINE_W-1:0] sine_entry_t;
    typedef sine_entry_t sine_lut_t [LUT_DEPTH];

    // per-word information handed from the control stage to the scaler
    typedef struct packed {
        logic        active;
        logic        playing;
        logic        accepted;
        logic        neg;
        sine_entry_t entry;
    } item_t;

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t       lut;
        longint unsigned q;
        longint unsigned r;
        longint unsigned u;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned h;
        for (int k = 0; k < LUT_DEPTH; k++)
        begin
            q = (4 * longint'(k)) / LUT_DEPTH;
            r = 4 * longint'(k) - q * LUT_DEPTH;
            u = (r << Q_SHIFT) / LUT_DEPTH;
            if (q[0])
            begin
                u = Q_ONE - u;
            end
            x  = (u * HALF_PI) >> Q_SHIFT;
            x2 = (x * x) >> Q_SHIFT;
            h  = Q_ONE;
            h  = Q_ONE - (((x2 * h) >> Q_SHIFT) / 110);
            h  = Q_ONE - (((x2 * h) >> Q_SHIFT) / 72);
            h  = Q_ONE - (((x2 * h) >> Q_SHIFT) / 42);
            h  = Q_ONE - (((x2 * h) >> Q_SHIFT) / 20);
            h  = Q_ONE - (((x2 * h) >> Q_SHIFT) / 6);
            lut[k] = SINE_W'((x * h) >> Q_SHIFT);
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

// ===== hdl/tsg_ctrl.sv =====
// Tone state: phase accumulator, increment, timer and run flags.
// Decodes each accepted word and looks up the sine entry. Uses tsg_pkg.
`timescale 1ns / 1ps

module tsg_ctrl
    import tsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  mode_t             mode,
    input  logic [FREQ_W-1:0] frequency_hz,
    input  logic [DUR_W-1:0]  tone_len_ms,
    output item_t             item
);

    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [PHASE_BITS-1:0] inc_reg, inc_next;
    logic [DUR_W-1:0]      left_reg, left_next;
    logic                  running_reg, running_next;
    logic                  timed_reg, timed_next;

    logic                                 freq_ok;
    logic [FREQ_W+INC_WHOLE_W-1:0]        whole_prod;
    logic [FREQ_W+FRAC_M_W-1:0]           frac_prod;
    logic [PHASE_BITS-1:0]                inc_calc;
    logic [DUR_W-1:0]                     left_dec;
    logic [LUT_AW-1:0]                    k;
    logic                                 accepted;

    assign freq_ok = (frequency_hz >= FREQ_W'(FREQ_MIN)) &&
                     (frequency_hz <= FREQ_W'(FREQ_MAX));

    assign whole_prod = (FREQ_W+INC_WHOLE_W)'(frequency_hz) *
                        (FREQ_W+INC_WHOLE_W)'(INC_WHOLE);
    assign frac_prod  = (FREQ_W+FRAC_M_W)'(frequency_hz) *
                        (FREQ_W+FRAC_M_W)'(FRAC_M);
    assign inc_calc   = PHASE_BITS'(whole_prod) + PHASE_BITS'(frac_prod >> FRAC_SHIFT);

    assign left_dec = (left_reg != '0) ? left_reg - DUR_W'(1) : '0;
    assign k        = phase_reg[PHASE_BITS-1 -: LUT_AW];

    always_comb
    begin
        phase_next   = phase_reg;
        inc_next     = inc_reg;
        left_next    = left_reg;
        running_next = running_reg;
        timed_next   = timed_reg;
        accepted     = 1'b1;
        case (mode)
            MODE_SAMPLE:
            begin
                if (running_reg)
                begin
                    phase_next = phase_reg + inc_reg;
                end
            end
            MODE_MS_TICK:
            begin
                if (running_reg && timed_reg)
                begin
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        running_next = 1'b0;
                        timed_next   = 1'b0;
                    end
                end
            end
            MODE_START_TIME:
            begin
                if (!freq_ok)
                begin
                    accepted = 1'b0;
                end
                else
                begin
                    inc_next     = inc_calc;
                    left_next    = tone_len_ms;
                    timed_next   = (tone_len_ms != '0);
                    running_next = (tone_len_ms != '0);
                end
            end
            MODE_START_CONT:
            begin
                timed_next   = 1'b0;
                left_next    = '0;
                running_next = 1'b1;
            end
            MODE_STOP:
            begin
                running_next = 1'b0;
                timed_next   = 1'b0;
                left_next    = '0;
            end
            MODE_SET_FREQ:
            begin
                if (!freq_ok)
                begin
                    accepted = 1'b0;
                end
                else
                begin
                    inc_next = inc_calc;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        item.active   = (mode == MODE_SAMPLE) && running_reg;
        item.playing  = running_next;
        item.accepted = accepted;
        item.neg      = k[LUT_AW-1];
        item.entry    = SINE_LUT[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            inc_reg     <= PHASE_BITS'(INC_INIT);
            left_reg    <= '0;
            running_reg <= 1'b0;
            timed_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            inc_reg     <= inc_next;
            left_reg    <= left_next;
            running_reg <= running_next;
            timed_reg   <= timed_next;
        end
    end

endmodule

// ===== hdl/tsg_scale.sv =====
// Volume gain register and output stage: gain times sine entry,
// saturation and sign. Uses tsg_pkg.
`timescale 1ns / 1ps

module tsg_scale
    import tsg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [VOL_W-1:0]    cfg_wdata,
    input  logic                load,
    input  item_t               item,
    output logic [SAMPLE_W-1:0] sample,
    output logic                playing,
    output logic                accepted
);

    localparam int PROD_W = GAIN_W + SINE_W;
    localparam int MAG_W  = PROD_W - Q_SHIFT;

    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic [VOL_W-1:0]    vol_clip;
    logic [PROD_W-1:0]   prod;
    logic [MAG_W-1:0]    mag_full;
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W-1:0] sample_next;

    logic [SAMPLE_W-1:0] sample_reg;
    logic                playing_reg;
    logic                accepted_reg;

    assign vol_clip  = (cfg_wdata > VOL_W'(VOL_MAX)) ? VOL_W'(VOL_MAX) : cfg_wdata;
    assign gain_next = GAIN_W'(vol_clip) * GAIN_W'(GAIN_PER_PCT);

    assign prod     = PROD_W'(gain_reg) * PROD_W'(item.entry);
    assign mag_full = MAG_W'(prod >> Q_SHIFT);
    assign mag      = (mag_full > MAG_W'(PEAK)) ? SAMPLE_W'(PEAK) : SAMPLE_W'(mag_full);

    always_comb
    begin
        if (!item.active)
        begin
            sample_next = '0;
        end
        else if (item.neg)
        begin
            sample_next = SAMPLE_W'(0) - mag;
        end
        else
        begin
            sample_next = mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_W'(GAIN_INIT);
        end
        else if (cfg_we)
        begin
            gain_reg <= gain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg   <= sample_next;
            playing_reg  <= item.playing;
            accepted_reg <= item.accepted;
        end
    end

    assign sample   = sample_reg;
    assign playing  = playing_reg;
    assign accepted = accepted_reg;

endmodule

// ===== hdl/timed_sine_tone_generator_top.sv =====
// Top level of the timed sine tone generator: handshake and pipeline valids.
// Instantiates tsg_ctrl and tsg_scale; uses tsg_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel s_*: s_tuser carries the mode, s_tdata the frequency and
//   duration. Every accepted word yields exactly one result word on m_*.
//   Modes: sample tick, millisecond tick, start timed, start continuous,
//   stop, set frequency. In start timed and set frequency, a frequency outside
//   20..20000 Hz is refused (accepted = 0) and leaves the tone unchanged.
//   cfg_we/cfg_wdata write the volume in percent (values above 100 act as
//   100); write it only while no word is in flight.
//   Each result passes two register stages before it appears on m_*: state
//   update plus sine lookup, then gain multiply and saturation.
//   Throughput: one word per cycle while the output is not stalled by m_tready.
//   Reset: phase 0, tone 440 Hz, stopped, volume 100, no result pending.
//   When m_tready is low the result holds and one further word is still
//   taken into the middle stage; s_tready then drops until the output moves.

module timed_sine_tone_generator_top
    import tsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // frequency_hz[14:0], tone_len_ms[30:15], zero[31]
    input  logic [7:0]  s_tuser,   // mode[2:0], zero[7:3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // sample[14:0], playing[15], accepted[16], zero[23:17]
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);

    logic  in_fire;
    logic  out_free;
    logic  mid_move;
    logic  mid_valid_reg, mid_valid_next;
    logic  out_valid_reg, out_valid_next;
    item_t item_now;
    item_t mid_reg;

    logic [SAMPLE_W-1:0] sample;
    logic                playing;
    logic                accepted;

    assign out_free = !out_valid_reg || m_tready;
    assign mid_move = mid_valid_reg && out_free;
    assign s_tready = !mid_valid_reg || out_free;
    assign in_fire  = s_tvalid && s_tready;

    tsg_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (in_fire),
        .mode         (mode_t'(s_tuser[MODE_W-1:0])),
        .frequency_hz (s_tdata[FREQ_W-1:0]),
        .tone_len_ms  (s_tdata[FREQ_W+DUR_W-1:FREQ_W]),
        .item         (item_now)
    );

    always_comb
    begin
        mid_valid_next = in_fire ? 1'b1 : (mid_move ? 1'b0 : mid_valid_reg);
        if (mid_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mid_reg <= item_now;
        end
    end

    tsg_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .load      (mid_move),
        .item      (mid_reg),
        .sample    (sample),
        .playing   (playing),
        .accepted  (accepted)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, accepted, playing, sample};

endmodule
